// File: rtl/tbl_pkg.sv
// ----------------------------------------------------------------------------
// tbl_pkg
// Shared codes and types of the token bucket limiter.
// ----------------------------------------------------------------------------
package tbl_pkg;

   typedef enum logic [1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_TIMED_OUT = 2'd2,
      STATUS_BUSY      = 2'd3
   } status_type;

   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_ACQUIRE = 1'b1;

   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD   = 1'd1;

   typedef struct packed {
      logic       emit;
      status_type status;
      logic       pend_set;
      logic       pend_clear;
   } decide_type;

endpackage

// File: rtl/tbl_req_if.sv
// ----------------------------------------------------------------------------
// tbl_req_if
// Input channel: tick and acquire items with valid/ready.
// ----------------------------------------------------------------------------
interface tbl_req_if #(
   parameter int TOKEN_BITS = 16,
   parameter int TIME_BITS  = 32
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [TOKEN_BITS-1:0] token_count;
   logic [TIME_BITS-1:0]  timeout_ticks;
   logic                  wait_forever;

   modport source (
      output valid, req_type, token_count, timeout_ticks, wait_forever,
      input  ready
   );

   modport sink (
      input  valid, req_type, token_count, timeout_ticks, wait_forever,
      output ready
   );
endinterface

// File: rtl/tbl_rsp_if.sv
// ----------------------------------------------------------------------------
// tbl_rsp_if
// Result channel: decision status and token level with valid/ready.
// ----------------------------------------------------------------------------
interface tbl_rsp_if #(
   parameter int TOKEN_BITS = 16
);
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic signed [TOKEN_BITS:0] tokens_after;

   modport source (
      output valid, status, tokens_after,
      input  ready
   );

   modport sink (
      input  valid, status, tokens_after,
      output ready
   );
endinterface

// File: rtl/tbl_decide.sv
// ----------------------------------------------------------------------------
// tbl_decide
// Next-state and result logic for one tick or acquire item.
// ----------------------------------------------------------------------------
module tbl_decide
   import tbl_pkg::*;
#(
   parameter int TOKEN_BITS = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic                       item_type,
   input  logic [TOKEN_BITS-1:0]      item_count,
   input  logic [TIME_BITS-1:0]       item_timeout,
   input  logic                       item_forever,
   input  logic [TOKEN_BITS-1:0]      capacity,
   input  logic [TIME_BITS-1:0]       period,
   input  logic signed [TOKEN_BITS:0] level,
   input  logic [TIME_BITS-1:0]       phase,
   input  logic                       pend_valid,
   input  logic [TOKEN_BITS-1:0]      pend_count,
   input  logic [TIME_BITS-1:0]       pend_ticks,
   input  logic                       pend_forever,
   output logic signed [TOKEN_BITS:0] level_next,
   output logic [TIME_BITS-1:0]       phase_next,
   output logic [TIME_BITS-1:0]       pend_ticks_next,
   output decide_type                 decide
);

   logic [TIME_BITS-1:0]       phase_inc;
   logic                       refill_hit;
   logic signed [TOKEN_BITS:0] cap_s;
   logic signed [TOKEN_BITS:0] level_ref;
   logic                       ref_positive;
   logic                       level_positive;
   logic [TIME_BITS-1:0]       ticks_dec;

   assign phase_inc      = phase + {{(TIME_BITS-1){1'b0}}, 1'b1};
   assign refill_hit     = (phase_inc >= period);
   assign cap_s          = $signed({1'b0, capacity});
   assign level_ref      = (refill_hit && (level < cap_s)) ?
                           level + $signed({{TOKEN_BITS{1'b0}}, 1'b1}) : level;
   assign ref_positive   = !level_ref[TOKEN_BITS] && (level_ref != '0);
   assign level_positive = !level[TOKEN_BITS] && (level != '0);
   assign ticks_dec      = (pend_ticks != '0) ?
                           pend_ticks - {{(TIME_BITS-1){1'b0}}, 1'b1} : pend_ticks;

   always_comb begin
      level_next        = level;
      phase_next        = phase;
      pend_ticks_next   = pend_ticks;
      decide.emit       = 1'b0;
      decide.status     = STATUS_GRANTED;
      decide.pend_set   = 1'b0;
      decide.pend_clear = 1'b0;
      if (item_type == REQ_TICK) begin
         phase_next = refill_hit ? '0 : phase_inc;
         level_next = level_ref;
         if (pend_valid) begin
            if (ref_positive) begin
               level_next        = level_ref - $signed({1'b0, pend_count});
               decide.emit       = 1'b1;
               decide.status     = STATUS_GRANTED;
               decide.pend_clear = 1'b1;
            end else if (!pend_forever) begin
               pend_ticks_next = ticks_dec;
               if (ticks_dec == '0) begin
                  decide.emit       = 1'b1;
                  decide.status     = STATUS_TIMED_OUT;
                  decide.pend_clear = 1'b1;
               end
            end
         end
      end else begin
         if (item_count > capacity) begin
            decide.emit   = 1'b1;
            decide.status = STATUS_TOO_LARGE;
         end else if (pend_valid) begin
            decide.emit   = 1'b1;
            decide.status = STATUS_BUSY;
         end else if (level_positive) begin
            level_next    = level - $signed({1'b0, item_count});
            decide.emit   = 1'b1;
            decide.status = STATUS_GRANTED;
         end else if (!item_forever && (item_timeout == '0)) begin
            decide.emit   = 1'b1;
            decide.status = STATUS_TIMED_OUT;
         end else begin
            pend_ticks_next = item_timeout;
            decide.pend_set = 1'b1;
         end
      end
   end

endmodule

// File: rtl/token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// token_bucket_limiter
// Token bucket rate limiter with one pending slot for refused requests.
// ----------------------------------------------------------------------------
// Takes one tick or acquire item per cycle while the input is ready; an item
// that yields a result presents it from the output register in the cycle
// after its transfer. The input is ready whenever the output register is
// empty or being drained, so the sustained rate is one item per clock, as
// each item updates the token level, refill phase and pending slot at its
// transfer for the next. A tick yields a result only when it grants or expires
// the waiting request, and a refused request that starts waiting yields none.
module token_bucket_limiter
   import tbl_pkg::*;
#(
   parameter int TOKEN_BITS = 16,
   parameter int TIME_BITS  = 32,
   localparam int CSR_DATA_BITS = (TOKEN_BITS > TIME_BITS) ? TOKEN_BITS : TIME_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   tbl_req_if.sink                   req_chan,
   tbl_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam logic [TOKEN_BITS-1:0] CAPACITY_RESET = TOKEN_BITS'(16);
   localparam logic [TIME_BITS-1:0]  PERIOD_RESET   = TIME_BITS'(1000);

   logic [TOKEN_BITS-1:0]      capacity_ff;
   logic [TIME_BITS-1:0]       period_ff;
   logic signed [TOKEN_BITS:0] level_ff;
   logic signed [TOKEN_BITS:0] level_in;
   logic [TIME_BITS-1:0]       phase_ff;
   logic [TIME_BITS-1:0]       phase_in;
   logic                       pend_valid_ff;
   logic [TOKEN_BITS-1:0]      pend_count_ff;
   logic [TIME_BITS-1:0]       pend_ticks_ff;
   logic [TIME_BITS-1:0]       pend_ticks_in;
   logic                       pend_forever_ff;
   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic signed [TOKEN_BITS:0] rsp_tokens_ff;
   decide_type                 decide;
   logic                       req_transfer;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_transfer   = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.tokens_after = rsp_tokens_ff;

   tbl_decide #(
      .TOKEN_BITS (TOKEN_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_decide (
      .item_type       (req_chan.req_type),
      .item_count      (req_chan.token_count),
      .item_timeout    (req_chan.timeout_ticks),
      .item_forever    (req_chan.wait_forever),
      .capacity        (capacity_ff),
      .period          (period_ff),
      .level           (level_ff),
      .phase           (phase_ff),
      .pend_valid      (pend_valid_ff),
      .pend_count      (pend_count_ff),
      .pend_ticks      (pend_ticks_ff),
      .pend_forever    (pend_forever_ff),
      .level_next      (level_in),
      .phase_next      (phase_in),
      .pend_ticks_next (pend_ticks_in),
      .decide          (decide)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         period_ff   <= PERIOD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CAPACITY: capacity_ff <= csr_wdata[TOKEN_BITS-1:0];
            CSR_PERIOD:   period_ff   <= csr_wdata[TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= '0;
         phase_ff        <= '0;
         pend_valid_ff   <= 1'b0;
         pend_count_ff   <= '0;
         pend_ticks_ff   <= '0;
         pend_forever_ff <= 1'b0;
      end else if (req_transfer) begin
         level_ff      <= level_in;
         phase_ff      <= phase_in;
         pend_ticks_ff <= pend_ticks_in;
         if (decide.pend_set) begin
            pend_valid_ff   <= 1'b1;
            pend_count_ff   <= req_chan.token_count;
            pend_forever_ff <= req_chan.wait_forever;
         end else if (decide.pend_clear) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_transfer && decide.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer && decide.emit) begin
         rsp_status_ff <= decide.status;
         rsp_tokens_ff <= level_in;
      end
   end

endmodule
